@@ rtl/sfc_pkg.sv @@
// Shared types and constants for the sphere frustum culler.
`timescale 1ns / 1ps

package sfc_pkg;

    // Plane register layout: nx, ny, nz Q1.14 and d Q12.4, nx lowest
    localparam int NORM_W     = 16;
    localparam int NORM_FRAC  = 14;
    localparam int DIST_W     = 16;
    localparam int PLANE_W    = 64;
    localparam int NX_LSB     = 0;
    localparam int NY_LSB     = 16;
    localparam int NZ_LSB     = 32;
    localparam int D_LSB      = 48;

    localparam int NUM_PLANES = 6;
    localparam int CFG_IDX_W  = 3;

    // Control that travels with each beat down the cell chain
    typedef struct packed {
        logic valid;
        logic culled;
    } t_beat_ctl;

endpackage

@@ rtl/sfc_if.sv @@
// Channel interfaces: splat input, visible-index output, plane configuration.
`timescale 1ns / 1ps

interface sfc_splat_if #(
    parameter int COORD_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] center_x;
    logic signed [COORD_WIDTH-1:0] center_y;
    logic signed [COORD_WIDTH-1:0] center_z;
    logic signed [COORD_WIDTH-1:0] scale_x;
    logic signed [COORD_WIDTH-1:0] scale_y;
    logic signed [COORD_WIDTH-1:0] scale_z;
    logic                          start_of_pass;

    modport source (output valid, center_x, center_y, center_z,
                    scale_x, scale_y, scale_z, start_of_pass, input ready);
    modport sink   (input valid, center_x, center_y, center_z,
                    scale_x, scale_y, scale_z, start_of_pass, output ready);
endinterface

interface sfc_index_if #(
    parameter int INDEX_WIDTH = 32
);
    logic                   valid;
    logic                   ready;
    logic [INDEX_WIDTH-1:0] splat_index;

    modport source (output valid, splat_index, input ready);
    modport sink   (input valid, splat_index, output ready);
endinterface

interface sfc_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [sfc_pkg::CFG_IDX_W-1:0] index;
    logic [sfc_pkg::PLANE_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/sfc_front.sv @@
// Intake stage: bounding radius and running splat index.
`timescale 1ns / 1ps

module sfc_front #(
    parameter int COORD_WIDTH = 16,
    parameter int INDEX_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic signed [COORD_WIDTH-1:0] i_cx,
    input  logic signed [COORD_WIDTH-1:0] i_cy,
    input  logic signed [COORD_WIDTH-1:0] i_cz,
    input  logic signed [COORD_WIDTH-1:0] i_sx,
    input  logic signed [COORD_WIDTH-1:0] i_sy,
    input  logic signed [COORD_WIDTH-1:0] i_sz,
    input  logic                          i_sop,
    output sfc_pkg::t_beat_ctl            o_ctl,
    output logic signed [COORD_WIDTH-1:0] o_cx,
    output logic signed [COORD_WIDTH-1:0] o_cy,
    output logic signed [COORD_WIDTH-1:0] o_cz,
    output logic [COORD_WIDTH-2:0]        o_rad,
    output logic [INDEX_WIDTH-1:0]        o_idx
);

    sfc_pkg::t_beat_ctl            r_ctl;
    logic signed [COORD_WIDTH-1:0] r_cx, r_cy, r_cz;
    logic [COORD_WIDTH-2:0]        r_rad;
    logic [INDEX_WIDTH-1:0]        r_idx;
    logic [INDEX_WIDTH-1:0]        r_next_index;

    logic [COORD_WIDTH-2:0] ax, ay, az, amax, n_rad;
    logic [INDEX_WIDTH-1:0] n_idx;
    logic                   accept;

    // Saturating magnitude: the most negative code maps to the largest positive
    function automatic logic [COORD_WIDTH-2:0] sat_mag(input logic [COORD_WIDTH-1:0] v);
        logic [COORD_WIDTH-1:0] neg;
        neg = v[COORD_WIDTH-1] ? (~v + COORD_WIDTH'(1)) : v;
        return neg[COORD_WIDTH-1] ? {(COORD_WIDTH-1){1'b1}} : neg[COORD_WIDTH-2:0];
    endfunction

    always_comb begin
        ax   = sat_mag(i_sx);
        ay   = sat_mag(i_sy);
        az   = sat_mag(i_sz);
        amax = ax;
        if (ay > amax) begin
            amax = ay;
        end
        if (az > amax) begin
            amax = az;
        end
        // never less than one LSB
        n_rad  = (amax == '0) ? (COORD_WIDTH-1)'(1) : amax;
        n_idx  = i_sop ? '0 : r_next_index;
        accept = i_en && i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl        <= '0;
            r_next_index <= '0;
        end else begin
            if (i_en) begin
                r_ctl.valid  <= i_valid;
                r_ctl.culled <= 1'b0;
            end
            if (accept) begin
                r_next_index <= n_idx + INDEX_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cx  <= i_cx;
            r_cy  <= i_cy;
            r_cz  <= i_cz;
            r_rad <= n_rad;
            r_idx <= n_idx;
        end
    end

    assign o_ctl = r_ctl;
    assign o_cx  = r_cx;
    assign o_cy  = r_cy;
    assign o_cz  = r_cz;
    assign o_rad = r_rad;
    assign o_idx = r_idx;

endmodule

@@ rtl/sfc_cell.sv @@
// One plane cell: holds a plane and tests each passing splat against it.
`timescale 1ns / 1ps

module sfc_cell #(
    parameter int COORD_WIDTH = 16,
    parameter int INDEX_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_cfg_we,
    input  logic [sfc_pkg::PLANE_W-1:0]   i_cfg_data,
    input  sfc_pkg::t_beat_ctl            i_ctl,
    input  logic signed [COORD_WIDTH-1:0] i_cx,
    input  logic signed [COORD_WIDTH-1:0] i_cy,
    input  logic signed [COORD_WIDTH-1:0] i_cz,
    input  logic [COORD_WIDTH-2:0]        i_rad,
    input  logic [INDEX_WIDTH-1:0]        i_idx,
    output sfc_pkg::t_beat_ctl            o_ctl,
    output logic signed [COORD_WIDTH-1:0] o_cx,
    output logic signed [COORD_WIDTH-1:0] o_cy,
    output logic signed [COORD_WIDTH-1:0] o_cz,
    output logic [COORD_WIDTH-2:0]        o_rad,
    output logic [INDEX_WIDTH-1:0]        o_idx
);

    localparam int PW = sfc_pkg::NORM_W + COORD_WIDTH;
    localparam int SW = PW + 3;

    logic [sfc_pkg::PLANE_W-1:0] r_plane;

    // product stage
    sfc_pkg::t_beat_ctl            r_a_ctl;
    logic signed [PW-1:0]          r_px, r_py, r_pz;
    logic signed [COORD_WIDTH-1:0] r_a_cx, r_a_cy, r_a_cz;
    logic [COORD_WIDTH-2:0]        r_a_rad;
    logic [INDEX_WIDTH-1:0]        r_a_idx;

    // compare stage
    sfc_pkg::t_beat_ctl            r_b_ctl;
    logic signed [COORD_WIDTH-1:0] r_b_cx, r_b_cy, r_b_cz;
    logic [COORD_WIDTH-2:0]        r_b_rad;
    logic [INDEX_WIDTH-1:0]        r_b_idx;

    logic signed [sfc_pkg::NORM_W-1:0] nx, ny, nz;
    logic signed [sfc_pkg::DIST_W-1:0] plane_d;
    logic signed [PW-1:0]              n_px, n_py, n_pz;
    logic signed [SW-1:0]              d_term, r_term, sum;
    logic                              cull;

    always_comb begin
        nx      = r_plane[sfc_pkg::NX_LSB +: sfc_pkg::NORM_W];
        ny      = r_plane[sfc_pkg::NY_LSB +: sfc_pkg::NORM_W];
        nz      = r_plane[sfc_pkg::NZ_LSB +: sfc_pkg::NORM_W];
        plane_d = r_plane[sfc_pkg::D_LSB  +: sfc_pkg::DIST_W];
        n_px = PW'(nx) * PW'(i_cx);
        n_py = PW'(ny) * PW'(i_cy);
        n_pz = PW'(nz) * PW'(i_cz);
        // align d and radius to the 18 fraction bits of the dot product
        d_term = SW'(plane_d) <<< sfc_pkg::NORM_FRAC;
        r_term = SW'($signed({1'b0, r_a_rad})) <<< sfc_pkg::NORM_FRAC;
        // n.c + d < -r  is  n.c + d + r < 0
        sum  = SW'(r_px) + SW'(r_py) + SW'(r_pz) + d_term + r_term;
        cull = sum[SW-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane <= '0;
            r_a_ctl <= '0;
            r_b_ctl <= '0;
        end else begin
            if (i_cfg_we) begin
                r_plane <= i_cfg_data;
            end
            if (i_en) begin
                r_a_ctl        <= i_ctl;
                r_b_ctl.valid  <= r_a_ctl.valid;
                r_b_ctl.culled <= r_a_ctl.culled || cull;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px    <= n_px;
            r_py    <= n_py;
            r_pz    <= n_pz;
            r_a_cx  <= i_cx;
            r_a_cy  <= i_cy;
            r_a_cz  <= i_cz;
            r_a_rad <= i_rad;
            r_a_idx <= i_idx;
            r_b_cx  <= r_a_cx;
            r_b_cy  <= r_a_cy;
            r_b_cz  <= r_a_cz;
            r_b_rad <= r_a_rad;
            r_b_idx <= r_a_idx;
        end
    end

    assign o_ctl = r_b_ctl;
    assign o_cx  = r_b_cx;
    assign o_cy  = r_b_cy;
    assign o_cz  = r_b_cz;
    assign o_rad = r_b_rad;
    assign o_idx = r_b_idx;

endmodule

@@ rtl/sphere_frustum_cull.sv @@
// Top level: six-plane sphere culler built as a chain of plane cells.
//
//   channel   dir   modport  beat carries
//   i_splat   in    sink     center_x/y/z, scale_x/y/z, start_of_pass
//   o_vis     out   source   splat_index of a visible splat
//   i_cfg     in    sink     index (plane 0..5), data (packed plane)
//
// One splat enters per cycle unless o_vis stalls; a visible splat passes one
// intake register, then two registers in each of the six plane cells.
// Reset clears the planes, the splat index and all beat valids.
// A stall on o_vis freezes the whole chain; i_splat.ready is low only while a
// visible result waits in the output register. Culled beats leave no result.
`timescale 1ns / 1ps

module sphere_frustum_cull #(
    parameter int INDEX_WIDTH = 32,
    parameter int COORD_WIDTH = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    sfc_splat_if.sink  i_splat,
    sfc_index_if.source o_vis,
    sfc_cfg_if.sink    i_cfg
);

    localparam int NP = sfc_pkg::NUM_PLANES;

    sfc_pkg::t_beat_ctl            ctl [0:NP];
    logic signed [COORD_WIDTH-1:0] cx  [0:NP];
    logic signed [COORD_WIDTH-1:0] cy  [0:NP];
    logic signed [COORD_WIDTH-1:0] cz  [0:NP];
    logic [COORD_WIDTH-2:0]        rad [0:NP];
    logic [INDEX_WIDTH-1:0]        idx [0:NP];

    logic en;
    logic out_hold;

    // hold the chain only while a visible beat waits at the end
    assign out_hold = ctl[NP].valid && !ctl[NP].culled;
    assign en       = !out_hold || o_vis.ready;

    assign i_splat.ready = en;
    assign i_cfg.ready   = 1'b1;

    sfc_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_splat.valid),
        .i_cx    (i_splat.center_x),
        .i_cy    (i_splat.center_y),
        .i_cz    (i_splat.center_z),
        .i_sx    (i_splat.scale_x),
        .i_sy    (i_splat.scale_y),
        .i_sz    (i_splat.scale_z),
        .i_sop   (i_splat.start_of_pass),
        .o_ctl   (ctl[0]),
        .o_cx    (cx[0]),
        .o_cy    (cy[0]),
        .o_cz    (cz[0]),
        .o_rad   (rad[0]),
        .o_idx   (idx[0])
    );

    for (genvar k = 0; k < NP; k++) begin : g_cell
        logic cfg_we;
        assign cfg_we = i_cfg.valid && (i_cfg.index == sfc_pkg::CFG_IDX_W'(k));

        sfc_cell #(
            .COORD_WIDTH (COORD_WIDTH),
            .INDEX_WIDTH (INDEX_WIDTH)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_en       (en),
            .i_cfg_we   (cfg_we),
            .i_cfg_data (i_cfg.data),
            .i_ctl      (ctl[k]),
            .i_cx       (cx[k]),
            .i_cy       (cy[k]),
            .i_cz       (cz[k]),
            .i_rad      (rad[k]),
            .i_idx      (idx[k]),
            .o_ctl      (ctl[k+1]),
            .o_cx       (cx[k+1]),
            .o_cy       (cy[k+1]),
            .o_cz       (cz[k+1]),
            .o_rad      (rad[k+1]),
            .o_idx      (idx[k+1])
        );
    end

    // the last cell's registers serve as the output register
    assign o_vis.valid       = out_hold;
    assign o_vis.splat_index = idx[NP];

endmodule

@@ tb/sv/sphere_frustum_cull_test.sv @@
// Self-checking bench for the six-plane sphere culler.
`timescale 1ns / 1ps

module sphere_frustum_cull_test;

    localparam int    HALF_PERIOD  = 4;
    localparam int    DRAIN_CYCLES = 24;
    localparam int    HOLD_CYCLES  = 300;
    localparam longint MAG_MAX     = 32767;
    localparam longint ONE_Q14     = 16384;

    typedef enum logic [sfc_pkg::CFG_IDX_W-1:0] {
        PLANE_LEFT, PLANE_RIGHT, PLANE_BOTTOM, PLANE_TOP,
        PLANE_NEAR, PLANE_FAR, PLANE_SPARE_6, PLANE_SPARE_7
    } t_plane_sel;

    typedef struct packed {
        logic [15:0] center_x;
        logic [15:0] center_y;
        logic [15:0] center_z;
        logic [15:0] scale_x;
        logic [15:0] scale_y;
        logic [15:0] scale_z;
        logic        start_of_pass;
    } t_splat;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sfc_splat_if #(.COORD_WIDTH(16)) splat_ch ();
    sfc_index_if #(.INDEX_WIDTH(32)) vis_ch ();
    sfc_cfg_if                       cfg_ch ();

    sphere_frustum_cull #(
        .INDEX_WIDTH(32),
        .COORD_WIDTH(16)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_splat (splat_ch),
        .o_vis   (vis_ch),
        .i_cfg   (cfg_ch)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Mirror of the block: plane registers and running splat index
    logic [sfc_pkg::PLANE_W-1:0] plane_q [sfc_pkg::NUM_PLANES];
    logic [31:0]                 run_index;

    t_splat      splat_backlog [$];
    logic [31:0] visible_idx_q [$];

    int   mismatch_count = 0;
    int   src_max = 0;
    int   rcv_max = 0;
    int   src_wait;
    int   rcv_wait;
    logic splat_beat;
    logic vis_beat;
    logic long_hold;
    bit   hold_arm = 1'b0;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic longint scale_mag(input logic [15:0] v);
        longint a;
        a = longint'($signed(v));
        if (a < 0) a = -a;
        if (a > MAG_MAX) a = MAG_MAX;
        return a;
    endfunction

    function automatic bit splat_visible(input t_splat s);
        longint rad, mag, cx, cy, cz, nx, ny, nz, plane_d, lhs;
        rad = scale_mag(s.scale_x);
        mag = scale_mag(s.scale_y);
        if (mag > rad) rad = mag;
        mag = scale_mag(s.scale_z);
        if (mag > rad) rad = mag;
        if (rad < 1) rad = 1;
        cx = longint'($signed(s.center_x));
        cy = longint'($signed(s.center_y));
        cz = longint'($signed(s.center_z));
        for (int p = 0; p < sfc_pkg::NUM_PLANES; p++) begin
            nx      = longint'($signed(plane_q[p][sfc_pkg::NX_LSB +: sfc_pkg::NORM_W]));
            ny      = longint'($signed(plane_q[p][sfc_pkg::NY_LSB +: sfc_pkg::NORM_W]));
            nz      = longint'($signed(plane_q[p][sfc_pkg::NZ_LSB +: sfc_pkg::NORM_W]));
            plane_d = longint'($signed(plane_q[p][sfc_pkg::D_LSB +: sfc_pkg::DIST_W]));
            lhs     = nx * cx + ny * cy + nz * cz + plane_d * ONE_Q14;
            if (lhs < -(rad * ONE_Q14)) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [sfc_pkg::PLANE_W-1:0] plane_word(input int nx, ny, nz, d);
        return {16'(d), 16'(nz), 16'(ny), 16'(nx)};
    endfunction

    function automatic logic [15:0] pick_value(input int span);
        if (span == 0) return 16'($urandom);
        return 16'($urandom_range(0, 2 * span) - span);
    endfunction

    function automatic t_splat mk_splat(input int cx, cy, cz, sx, sy, sz, input bit sop);
        t_splat s;
        s.center_x = 16'(cx);
        s.center_y = 16'(cy);
        s.center_z = 16'(cz);
        s.scale_x  = 16'(sx);
        s.scale_y  = 16'(sy);
        s.scale_z  = 16'(sz);
        s.start_of_pass = sop;
        return s;
    endfunction

    function automatic t_splat rand_splat(input int c_span);
        t_splat s;
        int     span;
        // a few centers roam the full range whatever the phase
        span = ($urandom_range(0, 7) == 0) ? 0 : c_span;
        s.center_x = pick_value(span);
        s.center_y = pick_value(span);
        s.center_z = pick_value(span);
        s.scale_x  = pick_value(32);
        s.scale_y  = pick_value(32);
        s.scale_z  = pick_value(32);
        case ($urandom_range(0, 15))
            0: begin
                s.scale_x = 16'($urandom);
                s.scale_y = 16'($urandom);
                s.scale_z = 16'($urandom);
            end
            1: s.scale_x = 16'h8000;
            2: s.scale_y = 16'h8000;
            3: s.scale_z = 16'h8000;
            4: begin
                s.scale_x = '0;
                s.scale_y = '0;
                s.scale_z = '0;
            end
            default: ;
        endcase
        s.start_of_pass = ($urandom_range(0, 63) == 0);
        return s;
    endfunction

    function automatic logic [sfc_pkg::PLANE_W-1:0] rand_plane();
        return plane_word($urandom, $urandom, $urandom, $urandom_range(0, 34767) - 2000);
    endfunction

    task automatic add_splat(input t_splat s);
        splat_backlog = {splat_backlog, s};
    endtask

    task automatic queue_random(input int count, input int c_span);
        repeat (count) add_splat(rand_splat(c_span));
    endtask

    task automatic set_pace(input int src, input int rcv);
        src_max = src;
        rcv_max = rcv;
    endtask

    // Hold until all splats are in and all visible indices out, then flush culled beats
    task automatic wait_drain();
        do @(posedge i_clk);
        while (splat_backlog.size() != 0 || splat_ch.valid || visible_idx_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_plane(input t_plane_sel sel, input logic [sfc_pkg::PLANE_W-1:0] val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= sel;
        cfg_ch.data  <= val;
        do @(posedge i_clk);
        while (!(cfg_ch.valid && cfg_ch.ready));
        if (int'(sel) < sfc_pkg::NUM_PLANES) plane_q[int'(sel)] = val;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic load_planes(input logic [sfc_pkg::PLANE_W-1:0] l, r, b, t, n, f);
        write_plane(PLANE_LEFT, l);
        write_plane(PLANE_RIGHT, r);
        write_plane(PLANE_BOTTOM, b);
        write_plane(PLANE_TOP, t);
        write_plane(PLANE_NEAR, n);
        write_plane(PLANE_FAR, f);
    endtask

    task automatic load_uniform(input logic [sfc_pkg::PLANE_W-1:0] w);
        load_planes(w, w, w, w, w, w);
    endtask

    // Axis-aligned box of half-size b (Q12.4) around the origin
    task automatic load_box(input int b);
        load_planes(plane_word(16384, 0, 0, b), plane_word(-16384, 0, 0, b),
                    plane_word(0, 16384, 0, b), plane_word(0, -16384, 0, b),
                    plane_word(0, 0, 16384, b), plane_word(0, 0, -16384, b));
    endtask

    // Splat driver
    always @(negedge i_clk) begin : splat_drive
        t_splat nxt;
        if (!i_rst_n) begin
            splat_ch.valid <= 1'b0;
            src_wait = 0;
        end else if (!splat_ch.valid || splat_beat) begin
            if (src_wait != 0) begin
                src_wait--;
                splat_ch.valid <= 1'b0;
            end else if (splat_backlog.size() != 0) begin
                nxt = splat_backlog.pop_front();
                splat_ch.center_x      <= nxt.center_x;
                splat_ch.center_y      <= nxt.center_y;
                splat_ch.center_z      <= nxt.center_z;
                splat_ch.scale_x       <= nxt.scale_x;
                splat_ch.scale_y       <= nxt.scale_y;
                splat_ch.scale_z       <= nxt.scale_z;
                splat_ch.start_of_pass <= nxt.start_of_pass;
                splat_ch.valid         <= 1'b1;
                src_wait = $urandom_range(0, src_max);
            end else begin
                splat_ch.valid <= 1'b0;
            end
        end
    end

    // Result receiver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            vis_ch.ready <= 1'b0;
            rcv_wait = 0;
        end else begin
            if (vis_beat) rcv_wait = $urandom_range(0, rcv_max);
            else if (rcv_wait != 0) rcv_wait--;
            vis_ch.ready <= (rcv_wait == 0) && !long_hold;
        end
    end

    // Long output stall so the chain fills and the input backs up
    initial begin
        long_hold = 1'b0;
        wait (hold_arm);
        @(posedge i_clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    // Monitor: check visible indices, predict each accepted splat
    always @(posedge i_clk) begin : monitor
        t_splat      s;
        logic [31:0] want;
        logic [31:0] idx;
        if (!i_rst_n) begin
            splat_beat <= 1'b0;
            vis_beat   <= 1'b0;
            run_index = '0;
        end else begin
            splat_beat <= splat_ch.valid && splat_ch.ready;
            vis_beat   <= vis_ch.valid && vis_ch.ready;
            if (vis_ch.valid && vis_ch.ready) begin
                if (visible_idx_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected index %0d", vis_ch.splat_index));
                end else begin
                    want = visible_idx_q.pop_front();
                    if (vis_ch.splat_index !== want)
                        report_mismatch($sformatf("splat_index %0d, want %0d",
                                                  vis_ch.splat_index, want));
                end
            end
            if (splat_ch.valid && splat_ch.ready) begin
                s.center_x      = splat_ch.center_x;
                s.center_y      = splat_ch.center_y;
                s.center_z      = splat_ch.center_z;
                s.scale_x       = splat_ch.scale_x;
                s.scale_y       = splat_ch.scale_y;
                s.scale_z       = splat_ch.scale_z;
                s.start_of_pass = splat_ch.start_of_pass;
                if (s.start_of_pass) run_index = '0;
                idx = run_index;
                run_index = run_index + 32'd1;
                if (splat_visible(s)) visible_idx_q = {visible_idx_q, idx};
            end
        end
    end

    initial begin
        for (int p = 0; p < sfc_pkg::NUM_PLANES; p++) plane_q[p] = '0;
        i_rst_n                = 1'b0;
        splat_ch.valid         = 1'b0;
        splat_ch.center_x      = '0;
        splat_ch.center_y      = '0;
        splat_ch.center_z      = '0;
        splat_ch.scale_x       = '0;
        splat_ch.scale_y       = '0;
        splat_ch.scale_z       = '0;
        splat_ch.start_of_pass = 1'b0;
        vis_ch.ready           = 1'b0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.index           = PLANE_LEFT;
        cfg_ch.data            = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Planes still at reset: every splat is visible
        set_pace(6, 6);
        add_splat(mk_splat(0, 0, 0, 0, 0, 0, 1'b1));
        add_splat(mk_splat(32767, 32767, 32767, 32767, 32767, 32767, 1'b0));
        add_splat(mk_splat(-32768, -32768, -32768, -32768, -32768, -32768, 1'b0));
        add_splat(mk_splat(-1, -1, -1, -1, -1, -1, 1'b0));
        add_splat(mk_splat(21845, -21846, 21845, -21846, 21845, -21846, 1'b0));
        add_splat(mk_splat(-21846, 21845, -21846, 21845, -21846, 21845, 1'b1));
        add_splat(mk_splat(7, -9, 11, 0, 0, 0, 1'b0));
        add_splat(mk_splat(0, 0, 0, 0, 0, 0, 1'b0));
        wait_drain();

        // Box planes: radius edges, saturated scales, pass restarts
        load_box(1000);
        add_splat(mk_splat(-1001, 0, 0, 0, 0, 0, 1'b0));
        add_splat(mk_splat(-1002, 0, 0, 0, 0, 0, 1'b0));
        add_splat(mk_splat(1001, 0, 0, 0, 0, 0, 1'b0));
        add_splat(mk_splat(1002, 0, 0, 0, 0, 0, 1'b0));
        add_splat(mk_splat(0, -1002, 0, 0, 0, 0, 1'b0));
        add_splat(mk_splat(0, 0, 1002, 0, 0, 0, 1'b0));
        add_splat(mk_splat(-32768, 0, 0, -32768, 0, 0, 1'b0));
        add_splat(mk_splat(-32768, 0, 0, 0, -32767, 0, 1'b0));
        add_splat(mk_splat(-32768, 0, 0, 0, 0, 32767, 1'b0));
        add_splat(mk_splat(-32768, 0, 0, 16, 0, 0, 1'b0));
        add_splat(mk_splat(0, 0, 0, 0, 0, 0, 1'b1));
        add_splat(mk_splat(32767, 32767, 32767, 32767, -32768, 32767, 1'b0));
        add_splat(mk_splat(-32768, -32768, -32768, 0, 0, 0, 1'b1));
        add_splat(mk_splat(5, -5, 7, 3, -3, 0, 1'b0));
        add_splat(mk_splat(-1003, 0, 0, 1, 0, 0, 1'b0));
        add_splat(mk_splat(-1003, 0, 0, 0, 0, -2, 1'b0));
        add_splat(mk_splat(-1003, 0, 0, 0, 3, 0, 1'b0));
        queue_random(350, 4000);
        wait_drain();

        // Back to open planes; spare indexes must not disturb anything
        load_uniform('0);
        write_plane(PLANE_SPARE_6, {$urandom, $urandom});
        write_plane(PLANE_SPARE_7, {$urandom, $urandom});
        set_pace(0, 6);
        hold_arm = 1'b1;
        queue_random(250, 0);
        wait_drain();

        // Random planes, no idling on either side
        load_planes(rand_plane(), rand_plane(), rand_plane(),
                    rand_plane(), rand_plane(), rand_plane());
        set_pace(0, 0);
        queue_random(300, 2048);
        wait_drain();

        load_planes(rand_plane(), rand_plane(), rand_plane(),
                    rand_plane(), rand_plane(), rand_plane());
        set_pace(6, 6);
        queue_random(350, 2048);
        wait_drain();

        // Register extremes
        set_pace(3, 3);
        load_uniform({sfc_pkg::PLANE_W{1'b1}});
        queue_random(50, 0);
        wait_drain();
        load_uniform({4{16'h7FFF}});
        queue_random(50, 0);
        wait_drain();
        load_uniform({4{16'h8000}});
        queue_random(50, 0);
        wait_drain();
        load_planes({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
        queue_random(100, 0);
        wait_drain();

        load_box(3000);
        set_pace(2, 6);
        queue_random(300, 6000);
        wait_drain();

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
